[rtl/mlr_pkg.sv]
package mlr_pkg;

    // request kinds carried in the input tuser bit
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req_type;

    // configuration register map
    localparam int          REG_ADDR_W         = 3;
    localparam logic [REG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd0;

    localparam int          HEIGHT_W           = 11;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd480;

endpackage

[rtl/midpoint_line_rasterizer.sv]
// Midpoint (Bresenham) line rasterizer for all octants, one pixel per stream
// transaction. A start transaction (tuser = 0) carries both endpoints packed in
// tdata as start_x, start_y, end_x, end_y from bit 0 up; the block picks the
// major axis (x unless |dy| > |dx|), orders the endpoints so the major
// coordinate rises and returns the first pixel. Each step transaction
// (tuser = 1) returns the next pixel; a step with no line in progress returns
// a transaction with tuser = 0 and all other fields zero. A start while a line
// is in progress drops the old line. Returned rows are flipped to
// screen_height minus the logical y; the last pixel of a line has tlast set.
// Throughput is one transaction per clock while the skid register is empty;
// the position/decision registers close an add-and-compare loop. A two-entry
// output buffer (result register plus skid register) keeps the input side
// accepting while one result waits on a stalled consumer. screen_height sits
// at APB byte address 0 and must only be written while no line is being
// returned.
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // apb configuration port
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [mlr_pkg::REG_ADDR_W-1:0]        i_paddr,
    input  logic [31:0]                           i_pwdata,
    output logic [31:0]                           o_prdata,
    output logic                                  o_pready,
    // request stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // start_x, start_y, end_x, end_y (signed), zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // req_type
    input  logic                                  i_s_tuser,
    // pixel stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // pixel_x (signed), pixel_y (signed, one bit wider), zero padded to bytes
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0]   o_m_tdata,
    // pixel_valid
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast
);
    import mlr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = COORD_BITS + 3;          // decision and increments
    localparam int OUT_W = ((2*COORD_BITS+1+7)/8)*8;
    localparam int YW    = COORD_BITS + HEIGHT_W + 2; // y flip before truncation
    localparam int RW    = 2*COORD_BITS + 3;        // {valid, last, y, x}

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic [HEIGHT_W-1:0] r_height;
    logic                w_cfg_wr;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr == REG_SCREEN_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            r_height <= i_pwdata[HEIGHT_W-1:0];
        end
    end

    assign o_prdata = (i_paddr == REG_SCREEN_HEIGHT) ? 32'(r_height) : 32'd0;

    // ---------------------------------------------------------------
    // line state
    // ---------------------------------------------------------------
    logic signed [CB-1:0] r_major, r_minor, r_major_end;
    logic signed [DW-1:0] r_dec, r_inc_s, r_inc_d;
    logic                 r_minor_down, r_swapped, r_drawing;

    logic signed [CB-1:0] n_major, n_minor, n_major_end;
    logic signed [DW-1:0] n_dec, n_inc_s, n_inc_d;
    logic                 n_minor_down, n_swapped, n_drawing;

    // output buffer: result register and skid register
    logic          r_out_valid, r_skid_valid;
    logic [RW-1:0] r_out, r_skid;

    logic w_in_acc, w_out_acc;
    assign o_s_tready = !r_skid_valid;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = r_out_valid && i_m_tready;

    // endpoint unpacking and setup
    logic signed [CB-1:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [CB:0]   w_ddx, w_ddy;
    logic [CB-1:0]        w_dx, w_dy, w_maj_d, w_min_d;
    logic signed [CB-1:0] w_a0, w_b0, w_a1, w_b1;
    logic                 w_swap, w_order;
    logic                 w_is_step;

    assign w_x0 = i_s_tdata[CB-1:0];
    assign w_y0 = i_s_tdata[2*CB-1:CB];
    assign w_x1 = i_s_tdata[3*CB-1:2*CB];
    assign w_y1 = i_s_tdata[4*CB-1:3*CB];

    assign w_ddx   = {w_x1[CB-1], w_x1} - {w_x0[CB-1], w_x0};
    assign w_ddy   = {w_y1[CB-1], w_y1} - {w_y0[CB-1], w_y0};
    assign w_dx    = w_ddx[CB] ? CB'(-w_ddx) : w_ddx[CB-1:0];
    assign w_dy    = w_ddy[CB] ? CB'(-w_ddy) : w_ddy[CB-1:0];
    assign w_swap  = w_dy > w_dx;
    assign w_maj_d = w_swap ? w_dy : w_dx;
    assign w_min_d = w_swap ? w_dx : w_dy;

    // endpoints ordered so the major coordinate rises
    always_comb begin
        logic signed [CB-1:0] a0, b0, a1, b1;
        a0 = w_swap ? w_y0 : w_x0;
        b0 = w_swap ? w_x0 : w_y0;
        a1 = w_swap ? w_y1 : w_x1;
        b1 = w_swap ? w_x1 : w_y1;
        w_order = a0 > a1;
        w_a0 = w_order ? a1 : a0;
        w_b0 = w_order ? b1 : b0;
        w_a1 = w_order ? a0 : a1;
        w_b1 = w_order ? b0 : b1;
    end

    assign w_is_step = (t_req_type'(i_s_tuser) == REQ_STEP);

    // next line state
    always_comb begin
        n_major      = r_major;
        n_minor      = r_minor;
        n_major_end  = r_major_end;
        n_dec        = r_dec;
        n_inc_s      = r_inc_s;
        n_inc_d      = r_inc_d;
        n_minor_down = r_minor_down;
        n_swapped    = r_swapped;
        n_drawing    = r_drawing;
        if (!w_is_step) begin
            n_major      = w_a0;
            n_minor      = w_b0;
            n_major_end  = w_a1;
            n_minor_down = w_b0 > w_b1;
            n_swapped    = w_swap;
            n_inc_s      = $signed(DW'({w_min_d, 1'b0}));
            n_inc_d      = $signed(DW'({w_min_d, 1'b0})) - $signed(DW'({w_maj_d, 1'b0}));
            n_dec        = $signed(DW'({w_min_d, 1'b0})) - $signed(DW'(w_maj_d));
            n_drawing    = w_a0 != w_a1;
        end else if (r_drawing) begin
            n_major = r_major + CB'(1);
            // straight step when the decision is not positive
            if (r_dec[DW-1] || (r_dec == '0)) begin
                n_dec = r_dec + r_inc_s;
            end else begin
                n_dec   = r_dec + r_inc_d;
                n_minor = r_minor_down ? r_minor - CB'(1) : r_minor + CB'(1);
            end
            n_drawing = (r_major + CB'(1)) != r_major_end;
        end
    end

    // pixel from the updated state, with the row flipped
    logic signed [CB-1:0] w_px, w_ly;
    logic [YW-1:0]        w_yfull;
    logic [RW-1:0]        w_res;

    assign w_px    = n_swapped ? n_minor : n_major;
    assign w_ly    = n_swapped ? n_major : n_minor;
    assign w_yfull = YW'(r_height) - YW'(w_ly);

    always_comb begin
        if (w_is_step && !r_drawing) begin
            w_res = '0; // idle step: empty result
        end else begin
            w_res = {1'b1, !n_drawing, w_yfull[CB:0], w_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major      <= '0;
            r_minor      <= '0;
            r_major_end  <= '0;
            r_dec        <= '0;
            r_inc_s      <= '0;
            r_inc_d      <= '0;
            r_minor_down <= 1'b0;
            r_swapped    <= 1'b0;
            r_drawing    <= 1'b0;
        end else if (w_in_acc) begin
            r_major      <= n_major;
            r_minor      <= n_minor;
            r_major_end  <= n_major_end;
            r_dec        <= n_dec;
            r_inc_s      <= n_inc_s;
            r_inc_d      <= n_inc_d;
            r_minor_down <= n_minor_down;
            r_swapped    <= n_swapped;
            r_drawing    <= n_drawing;
        end
    end

    // ---------------------------------------------------------------
    // output buffer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_acc) begin
                // result register free this cycle: skid first, else new result
                r_out_valid  <= r_skid_valid || w_in_acc;
                r_skid_valid <= r_skid_valid && w_in_acc;
            end else if (w_in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_acc) begin
            r_out <= r_skid_valid ? r_skid : w_res;
            if (r_skid_valid && w_in_acc) begin
                r_skid <= w_res;
            end
        end else if (w_in_acc) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out[RW-1];
    assign o_m_tlast  = r_out[RW-2];
    assign o_m_tdata  = OUT_W'(r_out[2*CB:0]);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while result register is empty");

    a_drawing_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawing |-> (r_major != r_major_end))
        else $error("line in progress already at its end");

    a_idle_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (!o_m_tlast && (o_m_tdata == '0)))
        else $error("empty result carries data");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("result lost while output stalled");

endmodule
